### hdl/quadratic_root_solver_assert.svh
// Assertion macros shared by the quadratic root solver checkers.
// Depends on nothing; files that assert take it in by `include.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define QRS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Invariant checked at every rising clock edge outside reset.
`define QRS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("invariant failed");

`endif

### hdl/qrs_pkg.sv
// Package of the quadratic root solver: payload types and case codes.
// Depends on nothing; top, ends and checker use it by scoped names.
`timescale 1ns / 1ps

package qrs_pkg;

  // Coefficient width (signed Q8.8) and root width (signed fixed point).
  localparam int CoefW = 16;
  localparam int RootW = 32;

  // Result case codes.
  typedef enum logic [1:0] {
    CaseInfinite = 2'd0,
    CaseNone     = 2'd1,
    CaseOne      = 2'd2,
    CaseTwo      = 2'd3
  } root_case_e;

  typedef struct packed {
    logic signed [CoefW-1:0] coef_a;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
  } coef_t;

  typedef struct packed {
    root_case_e              root_case;
    logic signed [RootW-1:0] root_low;
    logic signed [RootW-1:0] root_high;
    logic                    saturated;
  } result_t;

endpackage

### hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, queue and back end.
// Depends on qrs_pkg, qrs_front and qrs_back.
//
//   channel   ports                      handshake
//   command   start, busy, coef_i        beat at start high, busy low
//   result    done_o, res_o              beat on each cycle done_o is high
//
// One coefficient triple can be taken every cycle while busy is low; the
// square root and both dividers are fully pipelined, one bit per stage.
// Reset clears every valid flag and the queue; no clearing pass is needed.
// The receiver cannot stall; busy rises only if the queue would overflow.
`timescale 1ns / 1ps

module quadratic_root_solver #(
  parameter int ROOT_FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  qrs_pkg::coef_t   coef_i,
  output logic             done_o,
  output qrs_pkg::result_t res_o
);

  localparam int CW     = qrs_pkg::CoefW;
  localparam int DW     = 2 * CW + 2;
  localparam int NNW    = CW + ROOT_FRAC_BITS + 1;
  localparam int DVW    = CW + 1;
  localparam int QEW    = 2 + NNW + DVW + DW;
  localparam int QDepth = 4;
  localparam int PW     = $clog2(QDepth);

  // Front end.
  logic                   f_push;
  qrs_pkg::root_case_e    f_case;
  logic signed [NNW-1:0]  f_num;
  logic signed [DVW-1:0]  f_den;
  logic [DW-1:0]          f_disc;
  logic [1:0]             f_inflight;

  qrs_front #(
    .ROOT_FRAC_BITS(ROOT_FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(start && !busy),
    .coef_i    (coef_i),
    .push_o    (f_push),
    .case_o    (f_case),
    .num_o     (f_num),
    .den_o     (f_den),
    .disc_o    (f_disc),
    .inflight_o(f_inflight)
  );

  // Queue between front and back end.
  logic [QEW-1:0] mem_q [QDepth];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [PW:0]    cnt_q, cnt_d;
  logic           pop;
  logic           rd_vld_q;
  logic [QEW-1:0] rd_q;

  assign pop   = (cnt_q != '0);
  assign cnt_d = cnt_q + {{PW{1'b0}}, f_push} - {{PW{1'b0}}, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      rptr_q   <= '0;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rd_vld_q <= pop;
      if (f_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_push) begin
      mem_q[wptr_q] <= {f_case, f_num, f_den, f_disc};
    end
    if (pop) begin
      rd_q <= mem_q[rptr_q];
    end
  end

  // Hold off new commands when the queue could not take all items in flight.
  assign busy = (cnt_q + (PW+1)'(f_inflight)) >= (PW+1)'(QDepth);

  // Back end.
  qrs_back #(
    .ROOT_FRAC_BITS(ROOT_FRAC_BITS)
  ) u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (rd_vld_q),
    .case_i(qrs_pkg::root_case_e'(rd_q[QEW-1 -: 2])),
    .num_i (rd_q[DVW+DW +: NNW]),
    .den_i (rd_q[DW +: DVW]),
    .disc_i(rd_q[DW-1:0]),
    .done_o(done_o),
    .res_o (res_o)
  );

endmodule

### hdl/qrs_front.sv
// Front end of the quadratic root solver: registers coefficients, forms the
// exact discriminant and classifies the equation. Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_front #(
  parameter int ROOT_FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  input  qrs_pkg::coef_t                          coef_i,
  output logic                                    push_o,
  output qrs_pkg::root_case_e                     case_o,
  output logic signed [qrs_pkg::CoefW+ROOT_FRAC_BITS:0] num_o,
  output logic signed [qrs_pkg::CoefW:0]          den_o,
  output logic [2*qrs_pkg::CoefW+1:0]             disc_o,
  output logic [1:0]                              inflight_o
);

  localparam int CW  = qrs_pkg::CoefW;
  localparam int DW  = 2 * CW + 2;
  localparam int NNW = CW + ROOT_FRAC_BITS + 1;

  logic                   v1_q, v2_q;
  logic signed [CW-1:0]   a1_q, b1_q, c1_q;
  logic signed [CW-1:0]   a2_q, b2_q, c2_q;
  logic signed [2*CW-1:0] bsq1, ac1;
  logic signed [2*CW-1:0] bsq2_q, ac2_q;

  // Stage one: coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= coef_i.coef_a;
    b1_q <= coef_i.coef_b;
    c1_q <= coef_i.coef_c;
  end

  // Stage two: the two products of the discriminant.
  assign bsq1 = b1_q * b1_q;
  assign ac1  = a1_q * c1_q;

  always_ff @(posedge clk_i) begin
    a2_q   <= a1_q;
    b2_q   <= b1_q;
    c2_q   <= c1_q;
    bsq2_q <= bsq1;
    ac2_q  <= ac1;
  end

  // Discriminant, numerator and divisor for the back end.
  always_comb begin
    logic signed [DW-1:0]  disc_s;
    logic signed [NNW-1:0] b_ext, c_ext;
    disc_s = {{2{bsq2_q[2*CW-1]}}, bsq2_q} - ({{2{ac2_q[2*CW-1]}}, ac2_q} <<< 2);
    b_ext  = {{(NNW-CW){b2_q[CW-1]}}, b2_q};
    c_ext  = {{(NNW-CW){c2_q[CW-1]}}, c2_q};
    case_o = qrs_pkg::CaseNone;
    num_o  = -(b_ext <<< ROOT_FRAC_BITS);
    den_o  = {a2_q, 1'b0};
    disc_o = '0;
    if (a2_q == '0) begin
      den_o = {b2_q[CW-1], b2_q};
      num_o = -(c_ext <<< ROOT_FRAC_BITS);
      if (b2_q != '0) begin
        case_o = qrs_pkg::CaseOne;
      end else if (c2_q == '0) begin
        case_o = qrs_pkg::CaseInfinite;
      end
    end else if (disc_s == '0) begin
      case_o = qrs_pkg::CaseOne;
    end else if (!disc_s[DW-1]) begin
      case_o = qrs_pkg::CaseTwo;
      disc_o = disc_s;
    end
  end

  assign push_o     = v2_q;
  assign inflight_o = {1'b0, v1_q} + {1'b0, v2_q};

endmodule

### hdl/qrs_sqrt.sv
// Pipelined integer square root, one root bit per stage, for the solver.
// Carries a side payload alongside. Depends on nothing.
`timescale 1ns / 1ps

module qrs_sqrt #(
  parameter int RAD_W  = 66,
  parameter int SIDE_W = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int QW = RAD_W / 2;
  localparam int RW = QW + 2;

  logic              vld_q  [QW];
  logic [RW-1:0]     rem_q  [QW];
  logic [QW-1:0]     root_q [QW];
  logic [RAD_W-1:0]  rad_q  [QW];
  logic [SIDE_W-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              vld_in;
    logic [RW-1:0]     rem_in;
    logic [QW-1:0]     root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW+1:0]     trem, trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign trem  = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = (trem >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? RW'(trem - trial) : RW'(trem);
      root_q[k] <= {root_in[QW-2:0], ge};
      rad_q[k]  <= rad_in << 2;
      side_q[k] <= side_in;
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign root_o = root_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

### hdl/qrs_div.sv
// Pipelined restoring divider with round-to-nearest, ties away from zero.
// One quotient bit per stage; carries a side payload. Depends on nothing.
`timescale 1ns / 1ps

module qrs_div #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              neg_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NUM_W:0]    quo_o,
  output logic              neg_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [NUM_W-1:0]  quo_q  [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic              neg_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vld_in, neg_in;
    logic [DEN_W-1:0]  rem_in, den_in;
    logic [NUM_W-1:0]  quo_in, num_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    part, dext;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign neg_in  = neg_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign num_in  = num_q[k-1];
      assign den_in  = den_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next dividend bit and subtract when it fits.
    assign part = {rem_in, num_in[NUM_W-1]};
    assign dext = {1'b0, den_in};
    assign ge   = (part >= dext);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? DEN_W'(part - dext) : part[DEN_W-1:0];
      quo_q[k]  <= {quo_in[NUM_W-2:0], ge};
      num_q[k]  <= num_in << 1;
      den_q[k]  <= den_in;
      neg_q[k]  <= neg_in;
      side_q[k] <= side_in;
    end
  end

  // Rounding stage: bump the quotient when twice the remainder reaches the divisor.
  logic           rnd_vld_q, rnd_neg_q;
  logic [NUM_W:0] rnd_quo_q;
  logic [SIDE_W-1:0] rnd_side_q;
  logic           up;

  assign up = ({rem_q[NUM_W-1], 1'b0} >= {1'b0, den_q[NUM_W-1]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_vld_q <= 1'b0;
    end else begin
      rnd_vld_q <= vld_q[NUM_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_quo_q  <= {1'b0, quo_q[NUM_W-1]} + {{NUM_W{1'b0}}, up};
    rnd_neg_q  <= neg_q[NUM_W-1];
    rnd_side_q <= side_q[NUM_W-1];
  end

  assign vld_o  = rnd_vld_q;
  assign quo_o  = rnd_quo_q;
  assign neg_o  = rnd_neg_q;
  assign side_o = rnd_side_q;

endmodule

### hdl/qrs_back.sv
// Back end of the quadratic root solver: square root of the discriminant,
// two rounded divisions, sorting and saturation. Depends on qrs_pkg,
// qrs_sqrt and qrs_div.
`timescale 1ns / 1ps

module qrs_back #(
  parameter int ROOT_FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    vld_i,
  input  qrs_pkg::root_case_e                     case_i,
  input  logic signed [qrs_pkg::CoefW+ROOT_FRAC_BITS:0] num_i,
  input  logic signed [qrs_pkg::CoefW:0]          den_i,
  input  logic [2*qrs_pkg::CoefW+1:0]             disc_i,
  output logic                                    done_o,
  output qrs_pkg::result_t                        res_o
);

  localparam int CW    = qrs_pkg::CoefW;
  localparam int RTW   = qrs_pkg::RootW;
  localparam int DW    = 2 * CW + 2;
  localparam int NNW   = CW + ROOT_FRAC_BITS + 1;
  localparam int DVW   = CW + 1;
  localparam int SW    = DW + 2 * ROOT_FRAC_BITS;
  localparam int QW    = SW / 2;
  localparam int SUMW  = (NNW > QW ? NNW : QW) + 2;
  localparam int NW    = SUMW - 1;
  localparam int RVW   = (NW + 2 > RTW + 1) ? NW + 2 : RTW + 1;
  localparam int SIDEW = 2 + NNW + DVW;
  localparam logic signed [RVW-1:0] RootMax = {{(RVW-RTW+1){1'b0}}, {(RTW-1){1'b1}}};
  localparam logic signed [RVW-1:0] RootMin = {{(RVW-RTW+1){1'b1}}, {(RTW-1){1'b0}}};

  // Square root of the scaled discriminant.
  logic             sq_vld;
  logic [QW-1:0]    sq_root;
  logic [SIDEW-1:0] sq_side;

  qrs_sqrt #(
    .RAD_W (SW),
    .SIDE_W(SIDEW)
  ) u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (vld_i),
    .rad_i ({disc_i, {(2*ROOT_FRAC_BITS){1'b0}}}),
    .side_i({case_i, num_i, den_i}),
    .vld_o (sq_vld),
    .root_o(sq_root),
    .side_o(sq_side)
  );

  // Prepare magnitudes and signs of both dividends and of the divisor.
  logic                 p_vld_q;
  logic [1:0]           p_case_q;
  logic [NW-1:0]        p_m1_q, p_m2_q;
  logic                 p_n1_q, p_n2_q;
  logic [DVW-1:0]       p_dm_q;
  logic [NW-1:0]        p_m1_d, p_m2_d;
  logic                 p_n1_d, p_n2_d;
  logic [DVW-1:0]       p_dm_d;

  always_comb begin
    logic signed [NNW-1:0] num;
    logic signed [DVW-1:0] den;
    logic signed [SUMW-1:0] nx, qx, s1, s2;
    num = sq_side[DVW +: NNW];
    den = sq_side[DVW-1:0];
    nx  = {{(SUMW-NNW){num[NNW-1]}}, num};
    qx  = {{(SUMW-QW){1'b0}}, sq_root};
    s1  = nx - qx;
    s2  = nx + qx;
    p_m1_d = s1[SUMW-1] ? NW'(-s1) : NW'(s1);
    p_m2_d = s2[SUMW-1] ? NW'(-s2) : NW'(s2);
    p_n1_d = s1[SUMW-1] ^ den[DVW-1];
    p_n2_d = s2[SUMW-1] ^ den[DVW-1];
    p_dm_d = den[DVW-1] ? DVW'(-den) : DVW'(den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p_case_q <= sq_side[SIDEW-1 -: 2];
    p_m1_q   <= p_m1_d;
    p_m2_q   <= p_m2_d;
    p_n1_q   <= p_n1_d;
    p_n2_q   <= p_n2_d;
    p_dm_q   <= p_dm_d;
  end

  // Two dividers run side by side, one per root.
  logic          d_vld;
  logic [NW:0]   d_quo1, d_quo2;
  logic          d_neg1, d_neg2;
  logic [1:0]    d_case;

  qrs_div #(
    .NUM_W (NW),
    .DEN_W (DVW),
    .SIDE_W(2)
  ) u_div_low (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (p_vld_q),
    .num_i (p_m1_q),
    .den_i (p_dm_q),
    .neg_i (p_n1_q),
    .side_i(p_case_q),
    .vld_o (d_vld),
    .quo_o (d_quo1),
    .neg_o (d_neg1),
    .side_o(d_case)
  );

  qrs_div #(
    .NUM_W (NW),
    .DEN_W (DVW),
    .SIDE_W(2)
  ) u_div_high (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (p_vld_q),
    .num_i (p_m2_q),
    .den_i (p_dm_q),
    .neg_i (p_n2_q),
    .side_i(p_case_q),
    .vld_o (),
    .quo_o (d_quo2),
    .neg_o (d_neg2),
    .side_o()
  );

  // Apply the quotient signs.
  logic                  g_vld_q;
  logic [1:0]            g_case_q;
  logic signed [RVW-1:0] g_r1_q, g_r2_q;
  logic signed [RVW-1:0] q1x, q2x;

  assign q1x = {{(RVW-NW-1){1'b0}}, d_quo1};
  assign q2x = {{(RVW-NW-1){1'b0}}, d_quo2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else begin
      g_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    g_case_q <= d_case;
    g_r1_q   <= d_neg1 ? -q1x : q1x;
    g_r2_q   <= d_neg2 ? -q2x : q2x;
  end

  // Sort the pair ascending.
  logic                  s_vld_q;
  logic [1:0]            s_case_q;
  logic signed [RVW-1:0] s_lo_q, s_hi_q;
  logic                  swap;

  assign swap = (g_r1_q > g_r2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= g_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_case_q <= g_case_q;
    s_lo_q   <= swap ? g_r2_q : g_r1_q;
    s_hi_q   <= swap ? g_r1_q : g_r2_q;
  end

  // Saturate and mask the unused root fields into the output register.
  logic             done_q;
  qrs_pkg::result_t res_q, res_d;

  always_comb begin
    logic [RTW-1:0] lo_c, hi_c;
    logic           lo_sat, hi_sat;
    lo_sat = (s_lo_q > RootMax) || (s_lo_q < RootMin);
    hi_sat = (s_hi_q > RootMax) || (s_hi_q < RootMin);
    lo_c   = (s_lo_q > RootMax) ? RootMax[RTW-1:0] :
             (s_lo_q < RootMin) ? RootMin[RTW-1:0] : s_lo_q[RTW-1:0];
    hi_c   = (s_hi_q > RootMax) ? RootMax[RTW-1:0] :
             (s_hi_q < RootMin) ? RootMin[RTW-1:0] : s_hi_q[RTW-1:0];
    res_d.root_case = qrs_pkg::root_case_e'(s_case_q);
    res_d.root_low  = '0;
    res_d.root_high = '0;
    res_d.saturated = 1'b0;
    unique case (res_d.root_case)
      qrs_pkg::CaseOne: begin
        res_d.root_low  = lo_c;
        res_d.saturated = lo_sat;
      end
      qrs_pkg::CaseTwo: begin
        res_d.root_low  = lo_c;
        res_d.root_high = hi_c;
        res_d.saturated = lo_sat | hi_sat;
      end
      default: begin
        res_d.saturated = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/qrs_checker.sv
// Port-level checker for the quadratic root solver, with its bind.
// Depends on qrs_pkg and quadratic_root_solver_assert.svh.
`timescale 1ns / 1ps
`include "quadratic_root_solver_assert.svh"

module qrs_port_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input qrs_pkg::result_t res_o
);

  logic result_two, result_empty;

  // Classify each result beat by its case code.
  assign result_two   = done_o && (res_o.root_case == qrs_pkg::CaseTwo);
  assign result_empty = done_o && ((res_o.root_case == qrs_pkg::CaseNone) ||
                                   (res_o.root_case == qrs_pkg::CaseInfinite));

  // The back end never stalls, so the queue never fills.
  `QRS_ASSERT_ALWAYS(a_never_busy, clk_i, rst_ni, !busy)

  // The high root is reported only for two roots.
  `QRS_ASSERT_IMPL(a_high_unused, clk_i, rst_ni, done_o && !result_two, res_o.root_high == '0)

  // With no roots or infinitely many, the low field and the flag stay clear.
  `QRS_ASSERT_IMPL(a_no_root, clk_i, rst_ni, result_empty, res_o.root_low == '0 && !res_o.saturated)

  // Two roots leave the block in ascending order.
  `QRS_ASSERT_IMPL(a_sorted, clk_i, rst_ni, result_two, res_o.root_low <= res_o.root_high)

endmodule

bind quadratic_root_solver qrs_port_checker u_qrs_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .res_o (res_o)
);
